// ----- hdl/qenc_pkg.sv -----
// Shared types and constants for the four-channel x4 quadrature decoder.
// Used by the lane, scaling and top-level modules; no dependencies.
package qenc_pkg;

  localparam int NumEncoders   = 4;
  localparam int CountBits     = 16;
  localparam int PhaseBits     = 4;
  localparam int ChanBits      = 2;
  localparam int RecipBits     = 24;
  localparam int ReadCountBits = 16;
  localparam int RevBits       = 32;
  localparam int FracShift     = 16;

  localparam logic [RecipBits-1:0] RecipReset = 24'd71583;

  // One pin sample plus an optional read request
  typedef struct packed {
    logic [PhaseBits-1:0] phase_a;
    logic [PhaseBits-1:0] phase_b;
    logic                 read_request;
    logic [ChanBits-1:0]  read_channel;
  } qenc_in_t;

  // One read answer (all zero when no read)
  typedef struct packed {
    logic                            read_valid;
    logic signed [ReadCountBits-1:0] read_count;
    logic signed [RevBits-1:0]       revolutions_q16;
  } qenc_out_t;

endpackage

// ----- hdl/quad_encoder_x4_counter_top.sv -----
// Four-channel x4 quadrature decoder with read-and-clear counters.
// 3 register stages: selected count, product and output register.
// Throughput 1 item per cycle unless out_ready_i stalls; each count update feeds the next sample.
// Reset (async, active low) clears pin history, counts and pipeline valids and
// loads the reciprocal register with its default. No clearing pass is needed.
module quad_encoder_x4_counter_top #(
  parameter int NUM_ENCODERS = qenc_pkg::NumEncoders,
  parameter int COUNT_BITS   = qenc_pkg::CountBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  qenc_pkg::qenc_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output qenc_pkg::qenc_out_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [qenc_pkg::RecipBits-1:0] cfg_data_i
);

  logic [qenc_pkg::RecipBits-1:0] recip_q;
  logic                           in_xfer, rd_ok;
  logic                           rdy1, rdy2, rdy3;
  logic                           v1_q, v2_q, v3_q;
  logic                           rd1_q;
  logic signed [COUNT_BITS-1:0]   cnt1_q, sel_cnt;
  logic signed [COUNT_BITS-1:0]   cnt_next [NUM_ENCODERS];
  logic signed [COUNT_BITS-1:0]   cnt_cur  [NUM_ENCODERS];
  qenc_pkg::qenc_out_t            res2, res3_q;

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_q <= qenc_pkg::RecipReset;
    end else if (cfg_valid_i) begin
      recip_q <= cfg_data_i;
    end
  end

  // Pipeline handshake: a stage loads when it is empty or drains this cycle
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign in_xfer    = in_valid_i && rdy1;
  assign rd_ok      = in_data_i.read_request &&
                      (32'(in_data_i.read_channel) < NUM_ENCODERS);

  // Decoder lanes
  for (genvar i = 0; i < NUM_ENCODERS; i++) begin : g_lane
    logic pin_a, pin_b, clr;
    if (i < qenc_pkg::PhaseBits) begin : g_pin
      assign pin_a = in_data_i.phase_a[i];
      assign pin_b = in_data_i.phase_b[i];
    end else begin : g_nopin
      assign pin_a = 1'b0;
      assign pin_b = 1'b0;
    end
    assign clr = rd_ok && (32'(in_data_i.read_channel) == i);

    qenc_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (in_xfer),
      .clr_i      (clr),
      .a_i        (pin_a),
      .b_i        (pin_b),
      .cnt_next_o (cnt_next[i]),
      .cnt_o      (cnt_cur[i])
    );
  end

  // Merge: pick the updated count of the selected lane
  always_comb begin
    sel_cnt = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      if (rd_ok && 32'(in_data_i.read_channel) == i) sel_cnt = cnt_next[i];
    end
  end

  // Stage 1: selected count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd1_q  <= rd_ok;
      cnt1_q <= sel_cnt;
    end
  end

  // Stage 2: product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  qenc_scale #(.COUNT_BITS(COUNT_BITS)) u_scale (
    .clk_i   (clk_i),
    .en_i    (rdy2 && v1_q),
    .rd_i    (rd1_q),
    .cnt_i   (cnt1_q),
    .recip_i (recip_q),
    .res_o   (res2)
  );

  // Stage 3: output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      res3_q <= res2;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = res3_q;

  // Checks
  a_noread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.read_valid |->
      out_data_o.read_count == '0 && out_data_o.revolutions_q16 == '0)
    else $error("non-read result carries data");

  a_rev_sign_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_count >= 0 |-> out_data_o.revolutions_q16 >= 0)
    else $error("revolutions sign mismatch on non-negative count");

  a_rev_sign_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_count < 0 |-> out_data_o.revolutions_q16 <= 0)
    else $error("revolutions sign mismatch on negative count");

  a_clear_lane0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.read_request &&
    in_data_i.read_channel == '0 |=> cnt_cur[0] == '0)
    else $error("read did not clear channel 0");

endmodule

// ----- hdl/qenc_lane.sv -----
// One decoder lane: edge detection, x4 direction rules and saturating count.
// Depends on qenc_pkg for default widths.
module qenc_lane #(
  parameter int COUNT_BITS = qenc_pkg::CountBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         clr_i,
  input  logic                         a_i,
  input  logic                         b_i,
  output logic signed [COUNT_BITS-1:0] cnt_next_o,
  output logic signed [COUNT_BITS-1:0] cnt_o
);

  localparam logic signed [COUNT_BITS-1:0] CntMax = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CntMin = {1'b1, {(COUNT_BITS-1){1'b0}}};

  logic                         pa_q, pb_q;
  logic signed [COUNT_BITS-1:0] cnt_q;
  logic                         edge_a, edge_b, step, up;

  // Decode a single edge; simultaneous edges cancel
  always_comb begin
    edge_a = a_i ^ pa_q;
    edge_b = b_i ^ pb_q;
    step   = edge_a ^ edge_b;
    up     = edge_a ? (a_i == b_i) : (a_i != b_i);
    cnt_next_o = cnt_q;
    if (step) begin
      if (up && cnt_q != CntMax) begin
        cnt_next_o = cnt_q + COUNT_BITS'(1);
      end else if (!up && cnt_q != CntMin) begin
        cnt_next_o = cnt_q - COUNT_BITS'(1);
      end
    end
  end

  // Commit the sample and count on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q  <= 1'b0;
      pb_q  <= 1'b0;
      cnt_q <= '0;
    end else if (en_i) begin
      pa_q  <= a_i;
      pb_q  <= b_i;
      cnt_q <= clr_i ? '0 : cnt_next_o;
    end
  end

  assign cnt_o = cnt_q;

endmodule

// ----- hdl/qenc_scale.sv -----
// Merge output stage: clamp the read count, multiply by the Q0.32 reciprocal,
// then shift to Q16 and saturate. Depends on qenc_pkg.
module qenc_scale #(
  parameter int COUNT_BITS = qenc_pkg::CountBits
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic                                  rd_i,
  input  logic signed [COUNT_BITS-1:0]          cnt_i,
  input  logic [qenc_pkg::RecipBits-1:0]        recip_i,
  output qenc_pkg::qenc_out_t                   res_o
);

  localparam int PW = COUNT_BITS + qenc_pkg::RecipBits + 1;
  localparam int SW = PW - qenc_pkg::FracShift;
  localparam int RB = qenc_pkg::RevBits;
  localparam int CB = qenc_pkg::ReadCountBits;

  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [CB-1:0] cnt16_d, cnt16_q;
  logic                 rd_q;
  logic signed [SW-1:0] shifted;
  logic signed [RB-1:0] rev;

  // Clamp the count to the result field width
  if (COUNT_BITS <= CB) begin : g_cnt_ext
    assign cnt16_d = CB'(cnt_i);
  end else begin : g_cnt_sat
    localparam logic signed [COUNT_BITS-1:0] CMax =
      {{(COUNT_BITS-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CMin =
      {{(COUNT_BITS-CB+1){1'b1}}, {(CB-1){1'b0}}};
    always_comb begin
      if (cnt_i > CMax) cnt16_d = CMax[CB-1:0];
      else if (cnt_i < CMin) cnt16_d = CMin[CB-1:0];
      else cnt16_d = cnt_i[CB-1:0];
    end
  end

  assign prod_d = PW'(cnt_i) * $signed({1'b0, recip_i});

  // Register the product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      cnt16_q <= cnt16_d;
      rd_q    <= rd_i;
    end
  end

  // Arithmetic shift gives the floor; saturate to the revolutions width
  assign shifted = prod_q[PW-1:qenc_pkg::FracShift];

  if (SW <= RB) begin : g_rev_ext
    assign rev = RB'(shifted);
  end else begin : g_rev_sat
    localparam logic signed [SW-1:0] RMax = {{(SW-RB+1){1'b0}}, {(RB-1){1'b1}}};
    localparam logic signed [SW-1:0] RMin = {{(SW-RB+1){1'b1}}, {(RB-1){1'b0}}};
    always_comb begin
      if (shifted > RMax) rev = RMax[RB-1:0];
      else if (shifted < RMin) rev = RMin[RB-1:0];
      else rev = shifted[RB-1:0];
    end
  end

  always_comb begin
    res_o.read_valid      = rd_q;
    res_o.read_count      = cnt16_q;
    res_o.revolutions_q16 = rev;
  end

endmodule

// ----- sim/tb_quad_encoder_x4_counter_top.sv -----
// Self-checking testbench for the four-channel x4 quadrature decoder: pin samples with
// read requests go in, read answers are checked field by field against a local model.
// Depends on qenc_pkg and quad_encoder_x4_counter_top from the hdl folder.
module tb_quad_encoder_x4_counter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qenc_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 12;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 8;
  localparam int DirSteps      = 200;
  localparam int BatchItems    = 250;
  localparam int MaxPrinted    = 40;

  // Track pin history, counts and reciprocal; hold the answers still owed by the block
  class qenc_count_tracker;
    logic [PhaseBits-1:0] last_a;
    logic [PhaseBits-1:0] last_b;
    int                   counts[NumEncoders];
    logic [RecipBits-1:0] recip;
    qenc_out_t            pending_answers[$];
    int                   errors;

    function new();
      last_a = '0;
      last_b = '0;
      foreach (counts[i]) counts[i] = 0;
      recip  = RecipReset;
      errors = 0;
    endfunction

    static function longint saturate(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    task report(string what);
      errors++;
      if (errors <= MaxPrinted) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Apply the x4 edge rules to every channel, then answer a read and clear it
    function void note_sample(qenc_in_t s);
      qenc_out_t           ans;
      int                  step;
      longint              prod;
      logic [ChanBits-1:0] ch;
      for (int i = 0; i < NumEncoders; i++) begin
        step = 0;
        if (s.phase_a[i] != last_a[i]) step += (s.phase_a[i] == s.phase_b[i]) ? 1 : -1;
        if (s.phase_b[i] != last_b[i]) step += (s.phase_a[i] != s.phase_b[i]) ? 1 : -1;
        counts[i] = int'(saturate(counts[i] + step, CountBits));
      end
      last_a = s.phase_a;
      last_b = s.phase_b;
      ans = '0;
      ch  = s.read_channel;
      if (s.read_request && int'(ch) < NumEncoders) begin
        prod = longint'(counts[ch]) * longint'(recip);
        ans.read_valid      = 1'b1;
        ans.read_count      = ReadCountBits'(saturate(counts[ch], ReadCountBits));
        ans.revolutions_q16 = RevBits'(saturate(prod >>> FracShift, RevBits));
        counts[ch] = 0;
      end
      pending_answers.push_back(ans);
    endfunction

    task check_answer(qenc_out_t got);
      qenc_out_t want;
      if (pending_answers.size() == 0) begin
        report($sformatf("answer with none expected: valid %0b count %0d rev %0d",
                         got.read_valid, got.read_count, got.revolutions_q16));
        return;
      end
      want = pending_answers.pop_front();
      if (got.read_valid !== want.read_valid)
        report($sformatf("read_valid got %0b want %0b", got.read_valid, want.read_valid));
      if (got.read_count !== want.read_count)
        report($sformatf("read_count got %0d want %0d", got.read_count, want.read_count));
      if (got.revolutions_q16 !== want.revolutions_q16)
        report($sformatf("revolutions_q16 got %0d want %0d",
                         got.revolutions_q16, want.revolutions_q16));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  qenc_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  qenc_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [RecipBits-1:0] cfg_data;

  bit                   tx_idle_en;
  bit                   rx_idle_en;
  logic [PhaseBits-1:0] cur_a;
  logic [PhaseBits-1:0] cur_b;
  int                   idle_cycles = 0;
  qenc_count_tracker    tracker;

  quad_encoder_x4_counter_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Move one encoder a quarter step along its Gray sequence; dir is +1, -1 or 0
  function automatic logic [1:0] quad_step(logic a, logic b, int dir);
    logic [1:0] pos;
    pos = {a, a ^ b};
    pos = pos + 2'(dir);
    return {pos[1], pos[1] ^ pos[0]};
  endfunction

  // Drive one sample, with an optional idle burst ahead of it, and hold until transfer
  task automatic send_sample(logic [PhaseBits-1:0] a, logic [PhaseBits-1:0] b,
                             logic req, logic [ChanBits-1:0] ch);
    qenc_in_t s;
    s.phase_a      = a;
    s.phase_b      = b;
    s.read_request = req;
    s.read_channel = ch;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    cur_a = a;
    cur_b = b;
  endtask

  // Drop valid and wait until every owed answer has come back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (tracker.pending_answers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_recip(logic [RecipBits-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.recip = v;
  endtask

  // Mostly legal quarter steps per channel, some double flips, some fully random pins
  task automatic send_random_batch(int n);
    logic [PhaseBits-1:0] a;
    logic [PhaseBits-1:0] b;
    logic [1:0]           ab;
    int                   pick;
    repeat (n) begin
      a = cur_a;
      b = cur_b;
      if ($urandom_range(0, 9) == 0) begin
        a = PhaseBits'($urandom);
        b = PhaseBits'($urandom);
      end else begin
        for (int i = 0; i < NumEncoders; i++) begin
          pick = $urandom_range(0, 9);
          if (pick < 7) begin
            ab   = quad_step(cur_a[i], cur_b[i], (pick < 4) ? 1 : -1);
            a[i] = ab[1];
            b[i] = ab[0];
          end else if (pick == 9) begin
            a[i] = ~cur_a[i];
            b[i] = ~cur_b[i];
          end
        end
      end
      send_sample(a, b, $urandom_range(0, 3) == 0, ChanBits'($urandom_range(0, 3)));
    end
  endtask

  // Receiver: ready with random stall bursts while enabled
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Predict on every input transfer, check on every output transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) tracker.note_sample(in_data);
    if (rst_n && out_valid && out_ready) tracker.check_answer(out_data);
  end

  // Stop the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("** quad_encoder_x4_counter_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [1:0] ab0;
    logic [1:0] ab1;
    logic [PhaseBits-1:0] a;
    logic [PhaseBits-1:0] b;
    tracker    = new();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    cur_a      = '0;
    cur_b      = '0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: A-only edges, B-only edges, both phases at once, a full rotation, all channels
    send_sample(4'h0, 4'h0, 1'b1, 2'd0);
    send_sample(4'hF, 4'h0, 1'b1, 2'd1);
    send_sample(4'hF, 4'hF, 1'b1, 2'd2);
    send_sample(4'h0, 4'h0, 1'b1, 2'd3);
    send_sample(4'h0, 4'hF, 1'b0, 2'd3);
    send_sample(4'hF, 4'hF, 1'b0, 2'd0);
    send_sample(4'hF, 4'h0, 1'b0, 2'd1);
    send_sample(4'h0, 4'h0, 1'b1, 2'd0);
    send_sample(4'hF, 4'h0, 1'b0, 2'd2);
    send_sample(4'hF, 4'hF, 1'b0, 2'd2);
    send_sample(4'h0, 4'hF, 1'b1, 2'd1);
    send_sample(4'h5, 4'hA, 1'b1, 2'd2);
    send_sample(4'hA, 4'h5, 1'b1, 2'd3);
    send_sample(4'hA, 4'h5, 1'b0, 2'd1);
    send_sample(4'h3, 4'h6, 1'b1, 2'd0);
    send_sample(4'h3, 4'h6, 1'b1, 2'd1);
    send_sample(4'h3, 4'h6, 1'b1, 2'd2);
    send_sample(4'h3, 4'h6, 1'b1, 2'd3);
    pause_until_drained();

    // Long run: channel 0 forward, channel 1 backward, both read only at the end
    write_recip({RecipBits{1'b1}});
    tx_idle_en = 1'b0;
    repeat (DirSteps) begin
      ab0 = quad_step(cur_a[0], cur_b[0], 1);
      ab1 = quad_step(cur_a[1], cur_b[1], -1);
      a   = {2'($urandom), ab1[1], ab0[1]};
      b   = {2'($urandom), ab1[0], ab0[0]};
      send_sample(a, b, $urandom_range(0, 7) == 0, ChanBits'(2 + $urandom_range(0, 1)));
    end
    send_sample(cur_a, cur_b, 1'b1, 2'd0);
    send_sample(cur_a, cur_b, 1'b1, 2'd1);
    send_sample(cur_a, cur_b, 1'b1, 2'd0);
    pause_until_drained();

    // Random phases across reciprocal settings, extremes and zero among them
    tx_idle_en = 1'b1;
    write_recip(RecipBits'(1));
    send_random_batch(BatchItems / 2);
    pause_until_drained();
    send_random_batch(BatchItems / 2);
    pause_until_drained();
    write_recip('0);
    tx_idle_en = 1'b0;
    send_random_batch(BatchItems);
    pause_until_drained();
    write_recip(RecipBits'($urandom_range(1, (1 << RecipBits) - 1)));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b0;
    send_random_batch(BatchItems);
    pause_until_drained();
    write_recip({RecipBits{1'b1}});
    rx_idle_en = 1'b1;
    send_random_batch(BatchItems);
    pause_until_drained();
    write_recip(RecipReset);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_batch(BatchItems);
    pause_until_drained();

    if (tracker.errors == 0) begin
      $display("** quad_encoder_x4_counter_top: PASSED **");
    end else begin
      $display("** quad_encoder_x4_counter_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/qenc_pkg.sv
hdl/qenc_lane.sv
hdl/qenc_scale.sv
hdl/quad_encoder_x4_counter_top.sv
sim/tb_quad_encoder_x4_counter_top.sv
